// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the engine.
package i2cm_pkg;

	// Command codes carried on the operation field
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_STOP     = 3'd2;
	localparam logic [2:0] OP_WRITE    = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_WAIT_ACK = 3'd5;

	localparam logic [2:0]  TOP_BIT       = 3'd7;
	localparam logic [15:0] HALF_PER_RST  = 16'd250;

	// Command sequencer state, one-hot
	typedef enum logic [5:0] {
		CMD_IDLE     = 6'b000001,
		CMD_START    = 6'b000010,
		CMD_STOP     = 6'b000100,
		CMD_WRITE    = 6'b001000,
		CMD_READ     = 6'b010000,
		CMD_WAIT_ACK = 6'b100000
	} cmd_state_t;

	// Bus pin levels
	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
	} pins_t;

	// One result request
	typedef struct packed {
		pins_t      pins;
		logic       busy;
		logic       done;
		logic [7:0] read_byte;
		logic       ack_missing;
	} result_t;

endpackage

// ===== rtl/i2cm_core.sv =====
// Command sequencer of the I2C master bit engine: state registers and
// the per-tick next-state logic. Depends on i2cm_pkg.
module i2cm_core import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [15:0] half_period,
	input  logic [2:0]  operation,
	input  logic [7:0]  write_data,
	input  logic        ack_after_read,
	input  logic        sda_in,
	output result_t     nxt
);

	cmd_state_t cmd_q, cmd_n;
	logic [2:0]  phase_q, phase_n;
	logic [2:0]  bit_q, bit_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] dly_q, dly_n;
	logic        nack_q, nack_n;
	pins_t       pins_q, pins_n;
	logic        ack_q, ack_n;
	logic [7:0]  rres_q, rres_n;
	logic [15:0] hold_m1;
	logic        fin;
	logic        done;

	// Pin settings applied on entry to a phase
	function automatic pins_t enter_phase(cmd_state_t c, logic [2:0] ph, logic [2:0] bi,
	                                      logic [7:0] sh, logic ak, pins_t p);
		pins_t r;
		r = p;
		case (c)
			CMD_START: begin
				if (ph == 3'd0) begin
					r.drv = 1'b1; r.scl = 1'b1; r.sda = 1'b1;
				end else if (ph == 3'd1) begin
					r.sda = 1'b0;
				end else begin
					r.scl = 1'b0;
				end
			end
			CMD_STOP: begin
				if (ph == 3'd0) begin
					r.drv = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
				end else if (ph == 3'd1) begin
					r.scl = 1'b1;
				end else begin
					r.sda = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (ph == 3'd0) begin
					r.drv = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
				end else if (ph == 3'd1) begin
					r.sda = sh[bi];
				end else if (ph == 3'd2) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
				end
			end
			CMD_READ: begin
				if (ph == 3'd0) begin
					r.drv = 1'b0;
				end else if (ph == 3'd1) begin
					r.scl = 1'b1;
				end else if (ph == 3'd2) begin
					r.scl = 1'b0;
				end else if (ph == 3'd3) begin
					r.drv = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
				end else if (ph == 3'd4) begin
					if (ak) r.scl = 1'b1;
					else    r.sda = 1'b1;
				end else if (ph == 3'd5) begin
					r.scl = ~ak;
				end else begin
					r.scl = 1'b0;
				end
			end
			CMD_WAIT_ACK: begin
				if (ph == 3'd0) begin
					r.drv = 1'b0; r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
				end
			end
			default: r = p;
		endcase
		return r;
	endfunction

	// A zero period behaves as one tick
	assign hold_m1 = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;

	// Next state for one tick
	always_comb begin
		cmd_n   = cmd_q;
		phase_n = phase_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		dly_n   = dly_q;
		nack_n  = nack_q;
		pins_n  = pins_q;
		ack_n   = ack_q;
		rres_n  = rres_q;
		fin     = 1'b0;
		done    = 1'b0;
		if (cmd_q == CMD_IDLE) begin
			// new command, only from idle
			case (operation)
				OP_START:    cmd_n = CMD_START;
				OP_STOP:     cmd_n = CMD_STOP;
				OP_WRITE:    cmd_n = CMD_WRITE;
				OP_READ:     cmd_n = CMD_READ;
				OP_WAIT_ACK: cmd_n = CMD_WAIT_ACK;
				default:     cmd_n = CMD_IDLE;
			endcase
			if (cmd_n != CMD_IDLE) begin
				phase_n = 3'd0;
				bit_n   = TOP_BIT;
				if (cmd_n == CMD_WRITE) shift_n = write_data;
				if (cmd_n == CMD_READ) begin
					shift_n = 8'd0;
					ack_n   = ack_after_read;
				end
				pins_n = enter_phase(cmd_n, phase_n, bit_n, shift_n, ack_n, pins_q);
				dly_n  = hold_m1;
			end
		end else if (dly_q != 16'd0) begin
			dly_n = dly_q - 16'd1;
		end else begin
			// end of a phase
			case (cmd_q)
				CMD_START, CMD_STOP: begin
					if (phase_q >= 3'd2) fin = 1'b1;
					else phase_n = phase_q + 3'd1;
				end
				CMD_WRITE: begin
					if (phase_q < 3'd3) begin
						phase_n = phase_q + 3'd1;
					end else if (bit_q == 3'd0) begin
						fin = 1'b1;
					end else begin
						bit_n   = bit_q - 3'd1;
						phase_n = 3'd1;
					end
				end
				CMD_READ: begin
					if (phase_q == 3'd0) begin
						phase_n = 3'd1;
					end else if (phase_q == 3'd1) begin
						if (sda_in) shift_n[bit_q] = 1'b1;
						phase_n = 3'd2;
					end else if (phase_q == 3'd2) begin
						if (bit_q == 3'd0) begin
							rres_n  = shift_q;
							phase_n = 3'd3;
						end else begin
							bit_n   = bit_q - 3'd1;
							phase_n = 3'd1;
						end
					end else if (phase_q == 3'd3 || phase_q == 3'd4) begin
						phase_n = phase_q + 3'd1;
					end else if (phase_q == 3'd5 && !ack_q) begin
						phase_n = 3'd6;
					end else begin
						fin = 1'b1;
					end
				end
				CMD_WAIT_ACK: begin
					if (phase_q == 3'd0) begin
						nack_n  = sda_in;
						phase_n = 3'd1;
					end else begin
						pins_n.drv = 1'b1;
						fin        = 1'b1;
					end
				end
				default: fin = 1'b1;
			endcase
			if (fin) begin
				cmd_n   = CMD_IDLE;
				phase_n = 3'd0;
				bit_n   = TOP_BIT;
				done    = 1'b1;
			end else begin
				pins_n = enter_phase(cmd_q, phase_n, bit_n, shift_n, ack_q, pins_q);
				dly_n  = hold_m1;
			end
		end
	end

	// Result seen after this tick
	always_comb begin
		nxt.pins        = pins_n;
		nxt.busy        = (cmd_n != CMD_IDLE);
		nxt.done        = done;
		nxt.read_byte   = rres_n;
		nxt.ack_missing = nack_n;
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_IDLE;
			phase_q <= 3'd0;
			bit_q   <= TOP_BIT;
			shift_q <= 8'd0;
			dly_q   <= 16'd0;
			nack_q  <= 1'b0;
			pins_q  <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
			ack_q   <= 1'b0;
			rres_q  <= 8'd0;
		end else if (step_en) begin
			cmd_q   <= cmd_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			dly_q   <= dly_n;
			nack_q  <= nack_n;
			pins_q  <= pins_n;
			ack_q   <= ack_n;
			rres_q  <= rres_n;
		end
	end

`ifndef SYNTH
	// Every command leaves SDA driven when it returns to idle
	a_idle_drives: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q == CMD_IDLE |-> pins_q.drv)
		else $error("SDA released while idle");

	// Completion only comes out of a running command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && nxt.done |-> cmd_q != CMD_IDLE && dly_q == 16'd0)
		else $error("done without running command");

	// Phase counter stays within the start, stop, write and wait-ACK waveforms, and at zero while idle
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd_q == CMD_START || cmd_q == CMD_STOP) |-> phase_q <= 3'd2) and
		(cmd_q == CMD_WRITE |-> phase_q <= 3'd3) and
		(cmd_q == CMD_WAIT_ACK |-> phase_q <= 3'd1) and
		(cmd_q == CMD_IDLE |-> phase_q == 3'd0))
		else $error("phase out of range");
`endif

endmodule

// ===== rtl/i2cm_out_stage.sv =====
// Result register of the I2C master bit engine with its valid/stall
// handshake toward the consumer. Depends on i2cm_pkg.
module i2cm_out_stage import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_stall,
	output logic    out_valid,
	output logic    hold_off,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	// Upstream waits only while a held request cannot drain
	assign hold_off = valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | hold_off;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine: one input request is one bus timing tick and yields exactly one
// result request with the pin levels, busy, done, last read byte and ACK-missing flag.
// A tick is taken in every clock cycle unless the result register still holds an untaken
// result (out_stall high), and its result is presented in the cycle after acceptance; the
// next-state logic and the single result register set this one-tick-per-cycle rate.
// Commands are taken only while idle; each waveform phase lasts half_period_q ticks
// (zero acts as one). Depends on i2cm_pkg, i2cm_core and i2cm_out_stage.
module i2c_master_bit_engine import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  write_data,
	input  logic        ack_after_read,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_byte,
	output logic        ack_missing
);

	logic [15:0] half_period_q;
	logic        accept;
	result_t     nxt;
	result_t     res;

	// Phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PER_RST;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	assign accept = in_valid & ~in_stall;

	i2cm_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (accept),
		.half_period    (half_period_q),
		.operation      (operation),
		.write_data     (write_data),
		.ack_after_read (ack_after_read),
		.sda_in         (sda_in),
		.nxt            (nxt)
	);

	i2cm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_in    (nxt),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.hold_off  (in_stall),
		.res_out   (res)
	);

	// Result fields
	assign scl         = res.pins.scl;
	assign sda_out     = res.pins.sda;
	assign sda_drive   = res.pins.drv;
	assign busy_res    = res.busy;
	assign done_res    = res.done;
	assign read_byte   = res.read_byte;
	assign ack_missing = res.ack_missing;

endmodule

// ===== sim/i2c_master_bit_engine_tb.sv =====
`timescale 1ns / 100ps
// Testbench for i2c_master_bit_engine: feeds bus timing ticks carrying commands and SDA
// samples, predicts every result tick and checks it. Depends on i2cm_pkg and the engine RTL.
module i2c_master_bit_engine_tb;
	import i2cm_pkg::*;

	localparam logic [2:0] OP_NONE = 3'd0;

	// SDA pattern used while a directed command runs
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;

	// Idling patterns
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	typedef struct {
		logic [2:0] op;
		logic [7:0] data;
		logic       ack;
		logic       sda;
	} tick_req_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_wr_en      = 1'b0;
	logic [15:0] cfg_wr_data    = 16'd0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [2:0]  operation      = 3'd0;
	logic [7:0]  write_data     = 8'd0;
	logic        ack_after_read = 1'b0;
	logic        sda_in         = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic        scl;
	logic        sda_out;
	logic        sda_drive;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_byte;
	logic        ack_missing;

	i2c_master_bit_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.write_data(write_data),
		.ack_after_read(ack_after_read),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl(scl),
		.sda_out(sda_out),
		.sda_drive(sda_drive),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_byte(read_byte),
		.ack_missing(ack_missing)
	);

	always #10 clk = ~clk;

	tick_req_t pending_ticks[$];
	result_t   expected_ticks[$];
	tick_req_t drv_tick;
	result_t   head_tick;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        mismatches     = 0;
	int        ticks_checked  = 0;
	int        done_seen      = 0;
	int        settings_used  = 0;

	// Engine shadow state
	logic [15:0] half_ticks = HALF_PER_RST;
	logic [2:0]  cmd_kind   = OP_NONE;
	logic [3:0]  eng_phase  = 4'd0;
	logic [2:0]  bit_idx    = TOP_BIT;
	logic [7:0]  shifter    = 8'd0;
	logic [15:0] hold_left  = 16'd0;
	logic        nack_seen  = 1'b0;
	pins_t       pin_lv     = 3'b111;
	logic        ack_sel    = 1'b0;
	logic [7:0]  rd_result  = 8'd0;

	// Pin levels set on entry to the current phase
	function automatic void apply_phase_pins();
		case (cmd_kind)
		OP_START: begin
			if (eng_phase == 0) begin
				pin_lv.drv = 1'b1;
				pin_lv.scl = 1'b1;
				pin_lv.sda = 1'b1;
			end else if (eng_phase == 1) begin
				pin_lv.sda = 1'b0;
			end else begin
				pin_lv.scl = 1'b0;
			end
		end
		OP_STOP: begin
			if (eng_phase == 0) begin
				pin_lv.drv = 1'b1;
				pin_lv.scl = 1'b0;
				pin_lv.sda = 1'b0;
			end else if (eng_phase == 1) begin
				pin_lv.scl = 1'b1;
			end else begin
				pin_lv.sda = 1'b1;
			end
		end
		OP_WRITE: begin
			if (eng_phase == 0) begin
				pin_lv.drv = 1'b1;
				pin_lv.scl = 1'b0;
				pin_lv.sda = 1'b0;
			end else if (eng_phase == 1) begin
				pin_lv.sda = shifter[bit_idx];
			end else if (eng_phase == 2) begin
				pin_lv.scl = 1'b1;
			end else begin
				pin_lv.scl = 1'b0;
			end
		end
		OP_READ: begin
			case (eng_phase)
			4'd0: pin_lv.drv = 1'b0;
			4'd1: pin_lv.scl = 1'b1;
			4'd2: pin_lv.scl = 1'b0;
			4'd3: begin
				pin_lv.drv = 1'b1;
				pin_lv.scl = 1'b0;
				pin_lv.sda = 1'b0;
			end
			4'd4: begin
				if (ack_sel) pin_lv.scl = 1'b1;
				else pin_lv.sda = 1'b1;
			end
			4'd5: pin_lv.scl = !ack_sel;
			default: pin_lv.scl = 1'b0;
			endcase
		end
		OP_WAIT_ACK: begin
			if (eng_phase == 0) begin
				pin_lv.drv = 1'b0;
				pin_lv.scl = 1'b1;
			end else begin
				pin_lv.scl = 1'b0;
			end
		end
		default: ;
		endcase
	endfunction

	// Close the current phase; returns 1 when the command is complete
	function automatic logic phase_finished(logic sda);
		case (cmd_kind)
		OP_START, OP_STOP: begin
			if (eng_phase >= 2) return 1'b1;
			eng_phase++;
			return 1'b0;
		end
		OP_WRITE: begin
			if (eng_phase < 3) begin
				eng_phase++;
				return 1'b0;
			end
			if (bit_idx == 0) return 1'b1;
			bit_idx--;
			eng_phase = 4'd1;
			return 1'b0;
		end
		OP_READ: begin
			case (eng_phase)
			4'd0: eng_phase = 4'd1;
			4'd1: begin
				if (sda) shifter[bit_idx] = 1'b1;
				eng_phase = 4'd2;
			end
			4'd2: begin
				if (bit_idx == 0) begin
					rd_result = shifter;
					eng_phase = 4'd3;
				end else begin
					bit_idx--;
					eng_phase = 4'd1;
				end
			end
			4'd3, 4'd4: eng_phase++;
			4'd5: begin
				if (ack_sel) return 1'b1;
				eng_phase = 4'd6;
			end
			default: return 1'b1;
			endcase
			return 1'b0;
		end
		OP_WAIT_ACK: begin
			if (eng_phase == 0) begin
				nack_seen = sda;
				eng_phase = 4'd1;
				return 1'b0;
			end
			pin_lv.drv = 1'b1;
			return 1'b1;
		end
		default: return 1'b1;
		endcase
	endfunction

	// Advance the shadow engine by one tick and return the expected result
	function automatic result_t predict_bus_tick(tick_req_t t);
		logic [15:0] hold;
		logic        done;
		result_t     r;
		hold = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
		done = 1'b0;
		if (cmd_kind == OP_NONE) begin
			if (t.op >= OP_START && t.op <= OP_WAIT_ACK) begin
				cmd_kind  = t.op;
				eng_phase = 4'd0;
				bit_idx   = TOP_BIT;
				if (t.op == OP_WRITE) shifter = t.data;
				if (t.op == OP_READ) begin
					shifter = 8'd0;
					ack_sel = t.ack;
				end
				apply_phase_pins();
				hold_left = hold - 16'd1;
			end
		end else if (hold_left != 16'd0) begin
			hold_left--;
		end else if (phase_finished(t.sda)) begin
			cmd_kind  = OP_NONE;
			eng_phase = 4'd0;
			bit_idx   = TOP_BIT;
			done      = 1'b1;
		end else begin
			apply_phase_pins();
			hold_left = hold - 16'd1;
		end
		r.pins        = pin_lv;
		r.busy        = (cmd_kind != OP_NONE);
		r.done        = done;
		r.read_byte   = rd_result;
		r.ack_missing = nack_seen;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic push_tick(logic [2:0] op, logic [7:0] data, logic ack, logic sda);
		tick_req_t t;
		t.op   = op;
		t.data = data;
		t.ack  = ack;
		t.sda  = sda;
		pending_ticks.push_back(t);
	endtask

	function automatic logic pick_sda(int mode);
		if (mode == SDA_RAND) return 1'($urandom_range(1));
		return (mode == SDA_HIGH);
	endfunction

	// A command tick followed by gap idle ticks
	task automatic queue_cmd(logic [2:0] op, logic [7:0] data, logic ack, int sda_pat,
			int gap);
		push_tick(op, data, ack, pick_sda(sda_pat));
		repeat (gap)
			push_tick(OP_NONE, 8'($urandom), 1'($urandom_range(1)), pick_sda(sda_pat));
	endtask

	// Mostly commands spaced near their run time; random ops land while busy, plus noise
	task automatic queue_random(int n, logic [15:0] ticks);
		int         count;
		int         span;
		int         lim;
		logic [2:0] op;
		count = 0;
		while (count < n) begin
			if ($urandom_range(99) < 85) begin
				op = 3'($urandom_range(OP_WAIT_ACK, OP_START));
				case (op)
				OP_START, OP_STOP: span = 3;
				OP_WRITE: span = 25;
				OP_READ: span = 21;
				default: span = 2;
				endcase
				lim = span * ((ticks == 16'd0) ? 1 : int'(ticks)) + 3;
				if (lim > 90) lim = 90;
				if (lim > n - count - 1) lim = n - count - 1;
				if (lim < 0) lim = 0;
				push_tick(op, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
				count++;
				repeat ($urandom_range(lim)) begin
					op = ($urandom_range(99) < 25) ? 3'($urandom) : OP_NONE;
					push_tick(op, 8'($urandom), 1'($urandom_range(1)),
						1'($urandom_range(1)));
					count++;
				end
			end else begin
				push_tick(3'($urandom), 8'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				count++;
			end
		end
	endtask

	task automatic set_idling(int mode);
		case (mode)
		IDLE_SEND: begin
			send_idle_pct  = 64;
			recv_stall_pct = 0;
		end
		IDLE_RECV: begin
			send_idle_pct  = 0;
			recv_stall_pct = 64;
		end
		IDLE_BOTH: begin
			send_idle_pct  = 15;
			recv_stall_pct = 15;
		end
		default: begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		endcase
	endtask

	// Sender holds off until every request has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_ticks.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_half_period(logic [15:0] ticks);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ticks;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		half_ticks = ticks;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic run_segment(logic [15:0] ticks, int mode, int n);
		wait_drained();
		write_half_period(ticks);
		set_idling(mode);
		queue_random(n, ticks);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_ticks.push_back(predict_bus_tick(drv_tick));
			if (!in_valid || !in_stall) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_tick = pending_ticks.pop_front();
					operation      <= drv_tick.op;
					write_data     <= drv_tick.data;
					ack_after_read <= drv_tick.ack;
					sda_in         <= drv_tick.sda;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_ticks.size() == 0) begin
					report_mismatch("result with none expected", 16'd1, 16'd0);
				end else begin
					head_tick = expected_ticks.pop_front();
					ticks_checked++;
					if (head_tick.done) done_seen++;
					if (scl !== head_tick.pins.scl)
						report_mismatch("scl", 16'(scl), 16'(head_tick.pins.scl));
					if (sda_out !== head_tick.pins.sda)
						report_mismatch("sda_out", 16'(sda_out), 16'(head_tick.pins.sda));
					if (sda_drive !== head_tick.pins.drv)
						report_mismatch("sda_drive", 16'(sda_drive),
							16'(head_tick.pins.drv));
					if (busy_res !== head_tick.busy)
						report_mismatch("busy_res", 16'(busy_res), 16'(head_tick.busy));
					if (done_res !== head_tick.done)
						report_mismatch("done_res", 16'(done_res), 16'(head_tick.done));
					if (read_byte !== head_tick.read_byte)
						report_mismatch("read_byte", 16'(read_byte),
							16'(head_tick.read_byte));
					if (ack_missing !== head_tick.ack_missing)
						report_mismatch("ack_missing", 16'(ack_missing),
							16'(head_tick.ack_missing));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle ticks at the reset period, including the unused op codes
		set_idling(IDLE_NONE);
		push_tick(OP_NONE, 8'hFF, 1'b1, 1'b1);
		push_tick(3'd6, 8'h00, 1'b0, 1'b0);
		push_tick(3'd7, 8'hFF, 1'b1, 1'b1);
		push_tick(OP_NONE, 8'h00, 1'b0, 1'b0);
		wait_drained();

		// Directed commands at one tick per phase, each spaced to its run time
		write_half_period(16'd1);
		queue_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 3);
		queue_cmd(OP_WRITE, 8'h00, 1'b0, SDA_LOW, 25);
		queue_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH, 25);
		queue_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 25);
		queue_cmd(OP_READ, 8'h00, 1'b1, SDA_HIGH, 21);
		queue_cmd(OP_READ, 8'hFF, 1'b0, SDA_LOW, 21);
		queue_cmd(OP_READ, 8'h5A, 1'b1, SDA_RAND, 21);
		queue_cmd(OP_READ, 8'h3C, 1'b0, SDA_RAND, 21);
		queue_cmd(OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 2);
		queue_cmd(OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW, 2);
		queue_cmd(3'd6, 8'h00, 1'b0, SDA_RAND, 1);
		queue_cmd(3'd7, 8'hFF, 1'b1, SDA_RAND, 1);
		// write issued while busy is dropped
		queue_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 0);
		queue_cmd(OP_WRITE, 8'hC3, 1'b0, SDA_RAND, 1);
		// stop issued on the done tick is dropped, the next one is taken
		queue_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0);
		queue_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 2);
		queue_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0);
		queue_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 3);

		// Random phases over timing settings and idling patterns
		run_segment(16'd1, IDLE_NONE, 250);
		run_segment(16'd0, IDLE_SEND, 200);
		run_segment(16'd2, IDLE_RECV, 250);
		run_segment(16'd3, IDLE_BOTH, 250);
		run_segment(16'($urandom_range(6, 1)), IDLE_RECV, 200);
		run_segment(HALF_PER_RST, IDLE_NONE, 150);
		run_segment(16'hFFFF, IDLE_SEND, 50);

		wait_drained();
		repeat (4) @(negedge clk);
		$display("Checked %0d result ticks over %0d timing settings and four idling patterns,",
			ticks_checked, settings_used);
		$display("with %0d bus commands run to completion.", done_seen);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout: requests still outstanding");
		$display("== FAIL ==");
		$finish;
	end

endmodule
